// ----- rtl/rpf_pkg.sv -----
// Package for the RMS and power factor calculator.
// It holds the widths, register codes, reset values and payload structs.
// It has no dependencies; every RTL file of the block uses it.
`default_nettype none

package rpf_pkg;

  // Field widths and fixed-point scaling.
  localparam int SUM_W       = 48;
  localparam int CNT_W       = 16;
  localparam int FRAC_BITS   = 8;
  localparam int RMS_W       = 32;
  localparam int MP_W        = 48;
  localparam int PF_W        = 15;
  localparam int SP_W        = 15;
  localparam int THR_W       = 24;
  localparam int GAIN_W      = 16;
  localparam int OFF_W       = 15;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int GAIN_FRAC   = 16;
  localparam int PF_FRAC     = 14;

  // Derived sizes of the arithmetic pipeline.
  localparam int SCALED_W    = SUM_W + 2 * FRAC_BITS;
  localparam int SQ_W        = (SCALED_W + 1) / 2;
  localparam int SQ_IN_W     = 2 * SQ_W;
  localparam int DEN_W       = 2 * RMS_W;
  localparam int PF_SHIFT    = PF_FRAC + 2 * FRAC_BITS;
  localparam int PN_W        = SUM_W + PF_SHIFT;
  localparam int PR_W        = PN_W - PF_W;
  localparam int SPP_W       = GAIN_W + RMS_W;

  localparam logic [PF_W-1:0] PF_MAX = {PF_W{1'b1}};
  localparam logic [SP_W-1:0] SP_MAX = {SP_W{1'b1}};

  // Queue depths.
  localparam int IQ_DEPTH    = 4;
  localparam int IQ_PTR_W    = 2;
  localparam int OQ_DEPTH    = 2;
  localparam int OQ_PTR_W    = 1;

  // Register reset values.
  localparam logic [THR_W-1:0]  THR_RESET        = THR_W'(1900);
  localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_W'(43719);
  localparam logic [OFF_W-1:0]  OFF_BOOST_RESET  = OFF_W'(22587);
  localparam logic [OFF_W-1:0]  OFF_NORMAL_RESET = OFF_W'(18087);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_GAIN       = 2'd1,
    CFG_OFF_BOOST  = 2'd2,
    CFG_OFF_NORMAL = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]  boost_threshold;
    logic [GAIN_W-1:0] setpoint_gain;
    logic [OFF_W-1:0]  offset_boost;
    logic [OFF_W-1:0]  offset_normal;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] volt_square_sum;
    logic [SUM_W-1:0] curr_square_sum;
    logic [SUM_W-1:0] product_sum;
    logic [CNT_W-1:0] sample_count;
  } in_t;

  typedef struct packed {
    logic [RMS_W-1:0] volt_rms;
    logic [RMS_W-1:0] curr_rms;
    logic [MP_W-1:0]  mean_power;
    logic [PF_W-1:0]  power_factor;
    logic             boost_mode;
    logic [SP_W-1:0]  voltage_setpoint;
    logic             count_error;
  } out_t;

  // Request from the front queue to the back pipeline.
  typedef struct packed {
    in_t  item;
    logic zero;
  } fb_t;

endpackage

`default_nettype wire

// ----- rtl/rpf_front.sv -----
// Front part: accepts requests, flags a zero sample count, and queues them.
// Depends on rpf_pkg; feeds rpf_back.
`default_nettype none

module rpf_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  rpf_pkg::in_t      in_data_i,
  output logic              fb_valid_o,
  output rpf_pkg::fb_t      fb_data_o,
  input  wire logic         fb_pop_i
);

  rpf_pkg::fb_t mem_q [rpf_pkg::IQ_DEPTH];
  logic [rpf_pkg::IQ_PTR_W-1:0] wr_q, rd_q;
  logic [rpf_pkg::IQ_PTR_W:0]   cnt_q;
  logic wr_en, rd_en;

  assign full       = (cnt_q == (rpf_pkg::IQ_PTR_W + 1)'(rpf_pkg::IQ_DEPTH));
  assign fb_valid_o = (cnt_q != '0);
  assign fb_data_o  = mem_q[rd_q];
  assign wr_en      = push && !full;
  assign rd_en      = fb_pop_i && fb_valid_o;

  // Queue storage; the zero-count class is settled on entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q].item <= in_data_i;
      mem_q[wr_q].zero <= (in_data_i.sample_count == '0);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpf_back.sv -----
// Back part: pipelined division, square root, multiply and ratio stages.
// Depends on rpf_pkg; takes requests from rpf_front and feeds rpf_outq.
`default_nettype none

module rpf_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  rpf_pkg::cfg_t     cfg_i,
  input  wire logic         en_i,
  input  wire logic         fb_valid_i,
  input  rpf_pkg::fb_t      fb_data_i,
  output logic              res_valid_o,
  output rpf_pkg::out_t     res_data_o
);

  localparam int DIV_N = rpf_pkg::SCALED_W;
  localparam int SQ_N  = rpf_pkg::SQ_W;
  localparam int PF_N  = rpf_pkg::PF_W;
  localparam int CNT_W = rpf_pkg::CNT_W;
  localparam int SC_W  = rpf_pkg::SCALED_W;
  localparam int SQ_W  = rpf_pkg::SQ_W;
  localparam int SQI_W = rpf_pkg::SQ_IN_W;
  localparam int DEN_W = rpf_pkg::DEN_W;
  localparam int TS_W  = rpf_pkg::THR_W + rpf_pkg::FRAC_BITS;

  typedef struct packed {
    logic             zero;
    logic [CNT_W-1:0] cnt;
    logic [SC_W-1:0]  vn;
    logic [SC_W-1:0]  cn;
    logic [SC_W-1:0]  pn;
    logic [CNT_W-1:0] vr;
    logic [CNT_W-1:0] cr;
    logic [CNT_W-1:0] pr;
  } div_t;

  typedef struct packed {
    logic                     zero;
    logic [rpf_pkg::MP_W-1:0] mp;
    logic [SQI_W-1:0]         vx;
    logic [SQI_W-1:0]         cx;
    logic [SQ_W:0]            vrem;
    logic [SQ_W:0]            crem;
    logic [SQ_W-1:0]          vroot;
    logic [SQ_W-1:0]          croot;
  } sq_t;

  typedef struct packed {
    logic                      zero;
    logic [rpf_pkg::RMS_W-1:0] vr;
    logic [rpf_pkg::RMS_W-1:0] cr;
    logic [rpf_pkg::MP_W-1:0]  mp;
    logic [DEN_W-1:0]          den;
    logic [rpf_pkg::SPP_W-1:0] spp;
    logic                      boost;
  } mul_t;

  typedef struct packed {
    logic                      zero;
    logic [rpf_pkg::RMS_W-1:0] vr;
    logic [rpf_pkg::RMS_W-1:0] cr;
    logic [rpf_pkg::MP_W-1:0]  mp;
    logic [DEN_W-1:0]          den;
    logic [DEN_W-1:0]          r;
    logic [PF_N-1:0]           nlo;
    logic [PF_N-1:0]           q;
    logic                      sat;
    logic                      mpz;
    logic [rpf_pkg::SP_W-1:0]  sp;
    logic                      boost;
  } pf_t;

  // One restoring division step: next numerator bit in, quotient bit out.
  function automatic logic [SC_W+CNT_W-1:0] div_step(input logic [SC_W-1:0] nq,
                                                      input logic [CNT_W-1:0] rem,
                                                      input logic [CNT_W-1:0] den);
    logic [CNT_W:0] t;
    logic           b;
    t = {rem, nq[SC_W-1]};
    b = (t >= {1'b0, den});
    if (b) t = t - {1'b0, den};
    return {t[CNT_W-1:0], nq[SC_W-2:0], b};
  endfunction

  // One digit-by-digit square root step on two radicand bits.
  function automatic logic [SQI_W+2*SQ_W:0] sq_step(input logic [SQI_W-1:0] x,
                                                   input logic [SQ_W:0] rem,
                                                   input logic [SQ_W-1:0] root);
    logic [SQ_W+2:0] t;
    logic [SQ_W+2:0] trial;
    logic            b;
    t     = {rem, x[SQI_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    b     = (t >= trial);
    if (b) t = t - trial;
    return {x[SQI_W-3:0], 2'b00, t[SQ_W:0], root[SQ_W-2:0], b};
  endfunction

  // Phase one: three parallel dividers by the sample count.
  logic [DIV_N-1:0] a_vld_q;
  div_t             a_q [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    div_t src, nxt;
    logic vld_src;
    if (k == 0) begin : g_src
      always_comb begin
        src      = '0;
        src.zero = fb_data_i.zero;
        src.cnt  = fb_data_i.item.sample_count;
        src.vn   = SC_W'(fb_data_i.item.volt_square_sum) << (2 * rpf_pkg::FRAC_BITS);
        src.cn   = SC_W'(fb_data_i.item.curr_square_sum) << (2 * rpf_pkg::FRAC_BITS);
        src.pn   = SC_W'(fb_data_i.item.product_sum);
      end
      assign vld_src = fb_valid_i;
    end else begin : g_src
      assign src     = a_q[k-1];
      assign vld_src = a_vld_q[k-1];
    end
    always_comb begin
      nxt      = src;
      {nxt.vr, nxt.vn} = div_step(src.vn, src.vr, src.cnt);
      {nxt.cr, nxt.cn} = div_step(src.cn, src.cr, src.cnt);
      {nxt.pr, nxt.pn} = div_step(src.pn, src.pr, src.cnt);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        a_vld_q[k] <= vld_src;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) a_q[k] <= nxt;
    end
  end

  // Phase two: two square root pipelines on the quotients.
  logic [SQ_N-1:0] b_vld_q;
  sq_t             b_q [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    sq_t  src, nxt;
    logic vld_src;
    if (k == 0) begin : g_src
      always_comb begin
        src      = '0;
        src.zero = a_q[DIV_N-1].zero;
        src.mp   = rpf_pkg::MP_W'(a_q[DIV_N-1].pn);
        src.vx   = SQI_W'(a_q[DIV_N-1].vn);
        src.cx   = SQI_W'(a_q[DIV_N-1].cn);
      end
      assign vld_src = a_vld_q[DIV_N-1];
    end else begin : g_src
      assign src     = b_q[k-1];
      assign vld_src = b_vld_q[k-1];
    end
    always_comb begin
      nxt = src;
      {nxt.vx, nxt.vrem, nxt.vroot} = sq_step(src.vx, src.vrem, src.vroot);
      {nxt.cx, nxt.crem, nxt.croot} = sq_step(src.cx, src.crem, src.croot);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        b_vld_q[k] <= vld_src;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) b_q[k] <= nxt;
    end
  end

  // Phase three: RMS product, setpoint product and boost compare.
  logic            c_vld_q;
  mul_t            c_q, c_d;
  logic [TS_W-1:0] thr_scaled;

  assign thr_scaled = TS_W'(cfg_i.boost_threshold) << rpf_pkg::FRAC_BITS;

  always_comb begin
    c_d       = '0;
    c_d.zero  = b_q[SQ_N-1].zero;
    c_d.mp    = b_q[SQ_N-1].mp;
    c_d.vr    = rpf_pkg::RMS_W'(b_q[SQ_N-1].vroot);
    c_d.cr    = rpf_pkg::RMS_W'(b_q[SQ_N-1].croot);
    c_d.den   = DEN_W'(c_d.vr) * DEN_W'(c_d.cr);
    c_d.spp   = rpf_pkg::SPP_W'(cfg_i.setpoint_gain) * rpf_pkg::SPP_W'(c_d.cr);
    c_d.boost = (c_d.vr > thr_scaled);
  end

  // Phase four: saturation test, ratio setup and setpoint finish.
  logic                      e_vld_q;
  pf_t                       e_q, e_d;
  logic [rpf_pkg::PN_W-1:0]  pnum;
  logic [rpf_pkg::PR_W-1:0]  rtop;
  logic [rpf_pkg::SPP_W-1:0] sp_sum;

  always_comb begin
    pnum   = rpf_pkg::PN_W'(c_q.mp) << rpf_pkg::PF_SHIFT;
    rtop   = pnum[rpf_pkg::PN_W-1:PF_N];
    sp_sum = (c_q.spp >> (rpf_pkg::GAIN_FRAC + rpf_pkg::FRAC_BITS))
           + rpf_pkg::SPP_W'(c_q.boost ? cfg_i.offset_boost : cfg_i.offset_normal);
    e_d       = '0;
    e_d.zero  = c_q.zero;
    e_d.vr    = c_q.vr;
    e_d.cr    = c_q.cr;
    e_d.mp    = c_q.mp;
    e_d.den   = c_q.den;
    e_d.boost = c_q.boost;
    e_d.mpz   = (c_q.mp == '0);
    e_d.sat   = !e_d.mpz && (rtop >= c_q.den);
    e_d.r     = DEN_W'(rtop);
    e_d.nlo   = pnum[PF_N-1:0];
    e_d.q     = '0;
    e_d.sp    = (sp_sum > rpf_pkg::SPP_W'(rpf_pkg::SP_MAX)) ? rpf_pkg::SP_MAX
                                                            : rpf_pkg::SP_W'(sp_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= b_vld_q[SQ_N-1];
      e_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      e_q <= e_d;
    end
  end

  // Phase five: power factor quotient, one bit per stage.
  logic [PF_N-1:0] d_vld_q;
  pf_t             d_q [PF_N];

  for (genvar k = 0; k < PF_N; k++) begin : g_pf
    pf_t            src, nxt;
    logic           vld_src;
    logic [DEN_W:0] t;
    logic           b;
    if (k == 0) begin : g_src
      assign src     = e_q;
      assign vld_src = e_vld_q;
    end else begin : g_src
      assign src     = d_q[k-1];
      assign vld_src = d_vld_q[k-1];
    end
    always_comb begin
      t   = {src.r, src.nlo[PF_N-1]};
      b   = (t >= {1'b0, src.den});
      if (b) t = t - {1'b0, src.den};
      nxt     = src;
      nxt.r   = t[DEN_W-1:0];
      nxt.nlo = {src.nlo[PF_N-2:0], 1'b0};
      nxt.q   = {src.q[PF_N-2:0], b};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        d_vld_q[k] <= vld_src;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) d_q[k] <= nxt;
    end
  end

  // Result assembly; a zero count clears every field but the error flag.
  always_comb begin
    res_data_o = '0;
    if (d_q[PF_N-1].zero) begin
      res_data_o.count_error = 1'b1;
    end else begin
      res_data_o.volt_rms         = d_q[PF_N-1].vr;
      res_data_o.curr_rms         = d_q[PF_N-1].cr;
      res_data_o.mean_power       = d_q[PF_N-1].mp;
      res_data_o.boost_mode       = d_q[PF_N-1].boost;
      res_data_o.voltage_setpoint = d_q[PF_N-1].sp;
      if (d_q[PF_N-1].sat) res_data_o.power_factor = rpf_pkg::PF_MAX;
      else if (d_q[PF_N-1].mpz) res_data_o.power_factor = '0;
      else res_data_o.power_factor = d_q[PF_N-1].q;
    end
  end

  assign res_valid_o = d_vld_q[PF_N-1];

endmodule

`default_nettype wire

// ----- rtl/rpf_outq.sv -----
// Result queue between the back pipeline and the receiver.
// Depends on rpf_pkg; fed by rpf_back.
`default_nettype none

module rpf_outq (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      res_valid_i,
  input  rpf_pkg::out_t  res_data_i,
  output logic           room_o,
  output logic           empty,
  input  wire logic      pop,
  output rpf_pkg::out_t  out_data_o
);

  rpf_pkg::out_t mem_q [rpf_pkg::OQ_DEPTH];
  logic [rpf_pkg::OQ_PTR_W-1:0] wr_q, rd_q;
  logic [rpf_pkg::OQ_PTR_W:0]   cnt_q;
  logic wr_en, rd_en;

  assign room_o     = (cnt_q != (rpf_pkg::OQ_PTR_W + 1)'(rpf_pkg::OQ_DEPTH));
  assign empty      = (cnt_q == '0);
  assign out_data_o = mem_q[rd_q];
  assign wr_en      = res_valid_i && room_o;
  assign rd_en      = pop && !empty;

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= res_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rms_power_factor_calculator_top.sv -----
// Top level of the RMS and power factor calculator.
// Depends on rpf_pkg, rpf_front, rpf_back and rpf_outq.
//
// Usage: each request carries three 48-bit window sums and a sample count.
// The input side is a queue: a request is taken when push is high and full
// is low. The result side is a queue too: the oldest result is shown while
// empty is low and is taken when pop is high. One result leaves per request.
// When nothing stalls, a request passes from accept to empty going low through
// the input queue, SCALED_W (64) divider stages, SQ_W (32) square root stages,
// one multiply stage, one setup stage, 15 power factor stages and the result
// queue. While it has room, the pipeline takes one request per cycle.
// When the receiver stalls, the two-entry result queue fills, the whole back
// pipeline holds, and the four-entry input queue then raises full.
// Configuration writes through cfg_we_i, cfg_idx_i and cfg_wdata_i take effect
// at once and are to be made while no request is in flight.
// Reset empties both queues, clears the pipeline and loads register defaults.
`default_nettype none

module rms_power_factor_calculator_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rpf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rpf_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                         push,
  output logic                              full,
  input  rpf_pkg::in_t                      in_data_i,
  output logic                              empty,
  input  wire logic                         pop,
  output rpf_pkg::out_t                     out_data_o
);

  rpf_pkg::cfg_t cfg_q;
  rpf_pkg::fb_t  fb_data;
  rpf_pkg::out_t res_data;
  logic          fb_valid, res_valid, room;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boost_threshold <= rpf_pkg::THR_RESET;
      cfg_q.setpoint_gain   <= rpf_pkg::GAIN_RESET;
      cfg_q.offset_boost    <= rpf_pkg::OFF_BOOST_RESET;
      cfg_q.offset_normal   <= rpf_pkg::OFF_NORMAL_RESET;
    end else if (cfg_we_i) begin
      unique case (rpf_pkg::cfg_idx_e'(cfg_idx_i))
        rpf_pkg::CFG_THRESHOLD:  cfg_q.boost_threshold <= cfg_wdata_i[rpf_pkg::THR_W-1:0];
        rpf_pkg::CFG_GAIN:       cfg_q.setpoint_gain   <= cfg_wdata_i[rpf_pkg::GAIN_W-1:0];
        rpf_pkg::CFG_OFF_BOOST:  cfg_q.offset_boost    <= cfg_wdata_i[rpf_pkg::OFF_W-1:0];
        rpf_pkg::CFG_OFF_NORMAL: cfg_q.offset_normal   <= cfg_wdata_i[rpf_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  rpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .fb_valid_o (fb_valid),
    .fb_data_o  (fb_data),
    .fb_pop_i   (room)
  );

  rpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .en_i        (room),
    .fb_valid_i  (fb_valid),
    .fb_data_i   (fb_data),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  rpf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_data_i  (res_data),
    .room_o      (room),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_rpf_checker.sv -----
// Checker for the RMS and power factor calculator: predicts each result from
// accepted requests and compares it with the popped result. Depends on rpf_pkg.
module tb_rpf_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [rpf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rpf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic          push,
  input  logic          full,
  input  rpf_pkg::in_t  in_data_i,
  input  logic          empty,
  input  logic          pop,
  input  rpf_pkg::out_t out_data_o,
  output int            fail_count_o,
  output int            pending_o,
  output int            seen_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rpf_pkg::*;

  cfg_t  regs;
  out_t  expected_results[$];

  // Integer square root by the bit-pair method, 64-bit argument.
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Full result for one request under the current register values.
  function automatic out_t compute_measures(in_t req);
    out_t        res;
    logic [63:0] cnt;
    logic [63:0] vr;
    logic [63:0] ir;
    logic [63:0] mp;
    logic [127:0] den;
    logic [127:0] pf;
    logic [63:0] sp;
    res = '0;
    cnt = 64'(req.sample_count);
    if (cnt == 0) begin
      res.count_error = 1'b1;
      return res;
    end
    vr = int_sqrt((64'(req.volt_square_sum) << (2 * FRAC_BITS)) / cnt) & 64'hFFFF_FFFF;
    ir = int_sqrt((64'(req.curr_square_sum) << (2 * FRAC_BITS)) / cnt) & 64'hFFFF_FFFF;
    mp = 64'(req.product_sum) / cnt;
    den = 128'(vr) * 128'(ir);
    if (den == 0) begin
      pf = (mp != 0) ? 128'(PF_MAX) : 128'd0;
    end else begin
      pf = (128'(mp) << (PF_FRAC + 2 * FRAC_BITS)) / den;
      if (pf > 128'(PF_MAX)) pf = 128'(PF_MAX);
    end
    res.volt_rms     = vr[31:0];
    res.curr_rms     = ir[31:0];
    res.mean_power   = mp[47:0];
    res.power_factor = pf[14:0];
    res.boost_mode   = vr > (64'(regs.boost_threshold) << FRAC_BITS);
    sp = (64'(regs.setpoint_gain) * ir) >> (GAIN_FRAC + FRAC_BITS);
    sp = sp + (res.boost_mode ? 64'(regs.offset_boost) : 64'(regs.offset_normal));
    if (sp > 64'(SP_MAX)) sp = 64'(SP_MAX);
    res.voltage_setpoint = sp[14:0];
    return res;
  endfunction

  assign pending_o = expected_results.size();

  // Track registers, predict on each accepted request, compare on each pop.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      regs <= '{boost_threshold: THR_RESET, setpoint_gain: GAIN_RESET,
                offset_boost: OFF_BOOST_RESET, offset_normal: OFF_NORMAL_RESET};
      expected_results.delete();
      fail_count_o <= 0;
      seen_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD:  regs.boost_threshold <= cfg_wdata_i[THR_W-1:0];
          CFG_GAIN:       regs.setpoint_gain   <= cfg_wdata_i[GAIN_W-1:0];
          CFG_OFF_BOOST:  regs.offset_boost    <= cfg_wdata_i[OFF_W-1:0];
          CFG_OFF_NORMAL: regs.offset_normal   <= cfg_wdata_i[OFF_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) expected_results.push_back(compute_measures(in_data_i));
      if (pop && !empty) begin
        seen_count_o <= seen_count_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data_o) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Top of the RMS and power factor calculator testbench: clock, reset,
// stimulus and verdict. Depends on rpf_pkg, the block and tb_rpf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_t  in_data_i = '0;
  out_t out_data_o;
  int   fail_count;
  int   pending;
  int   seen_count;
  int   idle_cycles = 0;
  int   request_count = 0;
  int   pop_wait = 0;
  bit   pop_gaps_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rms_power_factor_calculator_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .in_data_i, .empty, .pop, .out_data_o
  );

  tb_rpf_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .in_data_i, .empty, .pop, .out_data_o,
    .fail_count_o(fail_count), .pending_o(pending), .seen_count_o(seen_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls after each taken result, with stretches of steady popping.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_wait <= 0;
    end else if (!pop_gaps_on) begin
      pop <= 1'b1;
    end else if (pop_wait > 0) begin
      pop      <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
      if (pop && !empty) pop_wait <= gap_len();
    end
  end

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Hold the request until taken; with use_gaps set, then idle for a random gap.
  task automatic send_request(in_t req, bit use_gaps);
    int gap;
    push      <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (full);
    request_count++;
    gap = use_gaps ? gap_len() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic finish_phase();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly windows with squares and products consistent with a count, else random.
  function automatic in_t window_request();
    in_t  req;
    logic [63:0] cnt;
    logic [63:0] v;
    logic [63:0] c;
    int   mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      req = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) == 0) req.sample_count = '0;
      return req;
    end
    cnt = (mode < 7) ? 64'($urandom_range(1, 2000)) : 64'($urandom_range(1, 65535));
    v = 64'($urandom_range(0, 4000));
    c = 64'($urandom_range(0, 3000));
    req.sample_count    = cnt[15:0];
    req.volt_square_sum = 48'(v * v * cnt + 64'($urandom_range(0, 1000)));
    req.curr_square_sum = 48'(c * c * cnt + 64'($urandom_range(0, 1000)));
    req.product_sum     = 48'((v * c * cnt * 64'($urandom_range(0, 100))) / 100);
    return req;
  endfunction

  initial begin
    in_t req;
    int  ph;
    logic [47:0] ones;
    ones = '1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero count, zero RMS, saturating ratios.
    send_request('{ones, ones, ones, 16'hFFFF}, 1'b0);
    send_request('{ones, ones, ones, 16'd1}, 1'b0);
    send_request('{48'd0, 48'd0, 48'd0, 16'd1}, 1'b0);
    send_request('{ones, ones, ones, 16'd0}, 1'b0);
    send_request('{48'd0, 48'd5, 48'd9, 16'd3}, 1'b0);
    send_request('{48'd100, 48'd0, 48'd0, 16'd1}, 1'b0);
    send_request('{48'd1, 48'd1, ones, 16'd1}, 1'b0);
    send_request('{48'd3610000, 48'd10000, 48'd190000, 16'd1}, 1'b1);
    send_request('{48'd3620000, 48'd10000, 48'd190000, 16'd1}, 1'b1);
    send_request('{48'd100000000, ones, 48'd1, 16'd2}, 1'b1);
    send_request('{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_5555_AAAA,
                   16'hAAAA}, 1'b1);
    send_request('{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_AAAA_5555,
                   16'h5555}, 1'b1);
    send_request('{48'd1_000_000, 48'd1_000_000, 48'd1_000_000, 16'd1}, 1'b1);
    finish_phase();

    // Random phases, each under its own register setting; extremes first.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_THRESHOLD, '0);  write_reg(CFG_GAIN, 24'hFFFF);
          write_reg(CFG_OFF_BOOST, 24'h7FFF); write_reg(CFG_OFF_NORMAL, '0);
        end
        1: begin
          write_reg(CFG_THRESHOLD, 24'hFFFFFF); write_reg(CFG_GAIN, '0);
          write_reg(CFG_OFF_BOOST, '0); write_reg(CFG_OFF_NORMAL, 24'h7FFF);
        end
        default: begin
          write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(0, 4000)));
          write_reg(CFG_GAIN, CFG_W'($urandom_range(0, 65535)));
          write_reg(CFG_OFF_BOOST, CFG_W'($urandom_range(0, 32767)));
          write_reg(CFG_OFF_NORMAL, CFG_W'($urandom_range(0, 32767)));
        end
      endcase
      cfg_we_i <= 1'b0;
      pop_gaps_on = (ph != 3);
      repeat (180) begin
        req = window_request();
        send_request(req, ph != 4);
      end
      finish_phase();
    end

    $display("tb_top: %0d requests sent, %0d results checked over 7 register settings",
             request_count, seen_count);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/rpf_pkg.sv
rtl/rpf_front.sv
rtl/rpf_back.sv
rtl/rpf_outq.sv
rtl/rms_power_factor_calculator_top.sv
tb/tb_rpf_checker.sv
tb/tb_top.sv
